// ===== design/price_level_order_book_unit_assert.svh =====
// Assertion macros shared by the order book RTL.
`ifndef PRICE_LEVEL_ORDER_BOOK_UNIT_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_UNIT_ASSERT_SVH
// Same-cycle implication, sampled on clock, off during reset.
`define PLO_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("order book assertion failed");
// Next-cycle implication.
`define PLO_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("order book assertion failed");
`endif

// ===== design/plo_pkg.sv =====
// ----------------------------------------------------------------------------
// plo_pkg
// Types and constants of the price level order book.
// ----------------------------------------------------------------------------
package plo_pkg;

   localparam int PRICE_W   = 32;
   localparam int SIZE_W    = 31;
   localparam int MAX_FILLS = 16;
   localparam int FILL_IW   = 4;
   localparam int NFILL_W   = 5;

   localparam logic [1:0] ACT_FEED   = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_MARKET = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  symbol_index;
      logic        side_is_buy;
      logic [31:0] price_ticks;
      logic signed [31:0] quantity;
      logic [31:0] client_id;
   } req_type;

   typedef struct packed {
      logic        fill_valid;
      logic [31:0] fill_client_id;
      logic [30:0] fill_quantity;
      logic [31:0] fill_price_ticks;
      logic        bid_present;
      logic [31:0] best_bid_ticks;
      logic        ask_present;
      logic [31:0] best_ask_ticks;
      logic        status;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [SIZE_W-1:0]  size;
   } level_type;

   localparam int LVL_W = $bits(level_type);

   typedef enum logic [2:0] {
      CH_HOLD,
      CH_LOAD,
      CH_REMOVE,
      CH_INSERT,
      CH_UPDATE,
      CH_POP
   } chain_op_type;

   typedef struct packed {
      chain_op_type       op;
      logic               bid_side;
      logic [PRICE_W-1:0] price;
      logic [SIZE_W-1:0]  size;
   } cell_cmd_type;

endpackage

// ===== design/plo_cell.sv =====
// ----------------------------------------------------------------------------
// plo_cell
// One price level slot; shifts to or takes from its neighbors.
// ----------------------------------------------------------------------------
module plo_cell (
   input  logic                 clock,
   input  plo_pkg::cell_cmd_type cmd,
   input  logic                 valid,
   input  plo_pkg::level_type   load_lvl,
   input  plo_pkg::level_type   left_lvl,
   input  plo_pkg::level_type   right_lvl,
   input  logic                 left_better,
   input  logic                 left_match,
   output logic                 better,
   output logic                 match_pre,
   output plo_pkg::level_type   lvl
);
   import plo_pkg::*;

   level_type lvl_ff, lvl_in;
   logic      self_match;

   assign self_match = valid && (lvl_ff.price == cmd.price);
   assign match_pre  = left_match | self_match;
   assign better     = !valid || (cmd.bid_side ? (cmd.price > lvl_ff.price)
                                               : (cmd.price < lvl_ff.price));
   assign lvl        = lvl_ff;

   always_comb begin
      lvl_in = lvl_ff;
      case (cmd.op)
         CH_LOAD:   lvl_in = load_lvl;
         CH_REMOVE: if (match_pre) lvl_in = right_lvl;
         CH_INSERT: if (better) begin
            if (left_better) lvl_in = left_lvl;
            else begin
               lvl_in.price = cmd.price;
               lvl_in.size  = cmd.size;
            end
         end
         CH_UPDATE: if (self_match) lvl_in.size = cmd.size;
         CH_POP:    lvl_in = right_lvl;
         default:   lvl_in = lvl_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
   end

endmodule

// ===== design/plo_chain.sv =====
// ----------------------------------------------------------------------------
// plo_chain
// Row of level cells holding one side of one book, best level first.
// ----------------------------------------------------------------------------
module plo_chain #(
   parameter int LEVELS = 16,
   parameter int CW     = 5
) (
   input  logic                          clock,
   input  plo_pkg::cell_cmd_type         cmd,
   input  logic [CW-1:0]                 cnt,
   input  logic [LEVELS*plo_pkg::LVL_W-1:0] load_row,
   output logic [LEVELS*plo_pkg::LVL_W-1:0] row,
   output logic                          any_match,
   output plo_pkg::level_type            top_lvl
);
   import plo_pkg::*;

   level_type lvl    [LEVELS];
   logic      better [LEVELS];
   logic      mpre   [LEVELS];

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      level_type left_lvl, right_lvl;
      logic      left_better, left_match;
      if (i == 0) begin : g_first
         assign left_lvl    = '0;
         assign left_better = 1'b0;
         assign left_match  = 1'b0;
      end else begin : g_mid
         assign left_lvl    = lvl[i-1];
         assign left_better = better[i-1];
         assign left_match  = mpre[i-1];
      end
      if (i == LEVELS-1) begin : g_last
         assign right_lvl = '0;
      end else begin : g_inner
         assign right_lvl = lvl[i+1];
      end
      plo_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid       (CW'(i) < cnt),
         .load_lvl    (load_row[i*LVL_W +: LVL_W]),
         .left_lvl    (left_lvl),
         .right_lvl   (right_lvl),
         .left_better (left_better),
         .left_match  (left_match),
         .better      (better[i]),
         .match_pre   (mpre[i]),
         .lvl         (lvl[i])
      );
      assign row[i*LVL_W +: LVL_W] = lvl[i];
   end

   assign any_match = mpre[LEVELS-1];
   assign top_lvl   = lvl[0];

endmodule

// ===== design/price_level_order_book_unit.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book_unit
// Per-symbol price level book with feed updates, level sets, market orders.
// ----------------------------------------------------------------------------
// One transaction at a time. Each side of a book is a row of a memory; the
// bid row and then the ask row are read, loaded into a chain of level cells,
// changed, and written back (read, load, operate, write). A market order
// stays in the operate step for as long as it takes fills. Results then leave
// one per cycle while the output is taken. An out-of-range symbol skips the
// book and goes straight to the results. No clearing pass: a per-row valid
// bit makes an unwritten side read as empty.
// ----------------------------------------------------------------------------
`include "price_level_order_book_unit_assert.svh"

module price_level_order_book_unit #(
   parameter int NUM_SYMBOLS     = 8,
   parameter int LEVELS_PER_SIDE = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  plo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output plo_pkg::rsp_type rsp_data
);
   import plo_pkg::*;

   localparam int SYM_W    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int ROW_W    = SYM_W + 1;
   localparam int ROWS     = 2 * NUM_SYMBOLS;
   localparam int CW       = $clog2(LEVELS_PER_SIDE + 1);
   localparam int CELL_B   = LEVELS_PER_SIDE * LVL_W;
   localparam int ROW_BITS = CELL_B + CW;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_OP    = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // transaction latched at accept
   req_type            item_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic               side_ff;      // 1: bid pass, 0: ask pass
   logic               tgt_bid_ff;   // feed update goes to bids
   logic               status_ff;
   logic [SIZE_W-1:0]  rem_ff;
   logic [NFILL_W-1:0] nfill_ff;
   logic [NFILL_W-1:0] emit_ff;
   logic               bid_pres_ff, ask_pres_ff;
   logic [PRICE_W-1:0] bid_best_ff, ask_best_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;

   // side memory, one row per symbol and side
   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_ff;
   logic                rv_ff;
   logic [ROWS-1:0]     row_valid_ff;
   logic [ROW_W-1:0]    row;

   // fills of a market order, replayed once the book is final
   logic [SIZE_W-1:0]  fill_qty_ff   [MAX_FILLS];
   logic [PRICE_W-1:0] fill_price_ff [MAX_FILLS];

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   cell_cmd_type        cmd;
   logic [CELL_B-1:0]   chain_row;
   logic                any_match;
   level_type           top_lvl;

   logic               accept, positive, valid_sym, walking, walk_side, out_free;
   logic [SIZE_W-1:0]  take;
   logic [NFILL_W-1:0] nres;

   assign row       = {sym_ff, side_ff};
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign valid_sym = 32'(req_data.symbol_index) < NUM_SYMBOLS;
   assign positive  = !item_ff.quantity[31] && (item_ff.quantity != '0);
   assign walk_side = (item_ff.action == ACT_MARKET) && positive
                      && (side_ff != item_ff.side_is_buy);
   assign walking   = (cnt_ff != '0) && (rem_ff != '0) && (nfill_ff < NFILL_W'(MAX_FILLS));
   assign take      = (top_lvl.size < rem_ff) ? top_lvl.size : rem_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign nres      = (nfill_ff == '0) ? NFILL_W'(1) : nfill_ff;

   plo_chain #(.LEVELS(LEVELS_PER_SIDE), .CW(CW)) u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .cnt       (cnt_ff),
      .load_row  (rd_ff[CELL_B-1:0]),
      .row       (chain_row),
      .any_match (any_match),
      .top_lvl   (top_lvl)
   );

   // Operate-cycle decode: which chain op this side gets.
   logic do_put, do_remove, full;
   assign full = (cnt_ff == CW'(LEVELS_PER_SIDE));

   always_comb begin
      do_put    = 1'b0;
      do_remove = 1'b0;
      case (item_ff.action)
         ACT_FEED: begin
            if (!positive) do_remove = 1'b1;
            else if (side_ff) do_put = (cnt_ff != '0) && (item_ff.price_ticks <= top_lvl.price);
            else do_put = !tgt_bid_ff;
         end
         ACT_SET: begin
            if (side_ff == item_ff.side_is_buy) begin
               do_remove = !positive;
               do_put    = positive;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      cmd.op       = CH_HOLD;
      cmd.bid_side = side_ff;
      cmd.price    = item_ff.price_ticks;
      cmd.size     = item_ff.quantity[SIZE_W-1:0];
      cnt_in       = cnt_ff;
      if (state_ff == ST_LOAD) begin
         cmd.op = CH_LOAD;
         cnt_in = rv_ff ? rd_ff[ROW_BITS-1 -: CW] : '0;
      end else if (state_ff == ST_OP) begin
         if (walk_side) begin
            if (walking) begin
               if (top_lvl.size == take) begin
                  cmd.op = CH_POP;
                  cnt_in = cnt_ff - CW'(1);
               end else begin
                  cmd.op    = CH_UPDATE;
                  cmd.price = top_lvl.price;
                  cmd.size  = top_lvl.size - take;
               end
            end
         end else if (do_remove) begin
            cmd.op = CH_REMOVE;
            if (any_match) cnt_in = cnt_ff - CW'(1);
         end else if (do_put) begin
            if (any_match) cmd.op = CH_UPDATE;
            else if (!full) begin
               cmd.op = CH_INSERT;
               cnt_in = cnt_ff + CW'(1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = valid_sym ? ST_READ : ST_EMIT;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_OP;
         ST_OP:    if (!(walk_side && walking)) state_in = ST_WRITE;
         ST_WRITE: state_in = side_ff ? ST_READ : ST_EMIT;
         ST_EMIT:  if (out_free && (emit_ff + NFILL_W'(1) == nres)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // result build
   always_comb begin
      logic fv;
      fv = (nfill_ff != '0);
      rsp_in.fill_valid       = fv;
      rsp_in.fill_client_id   = fv ? item_ff.client_id : '0;
      rsp_in.fill_quantity    = fv ? fill_qty_ff[emit_ff[FILL_IW-1:0]] : '0;
      rsp_in.fill_price_ticks = fv ? fill_price_ff[emit_ff[FILL_IW-1:0]] : '0;
      rsp_in.bid_present      = bid_pres_ff;
      rsp_in.best_bid_ticks   = bid_best_ff;
      rsp_in.ask_present      = ask_pres_ff;
      rsp_in.best_ask_ticks   = ask_best_ff;
      rsp_in.status           = status_ff;
      rsp_in.last_result      = (emit_ff + NFILL_W'(1) == nres);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_WRITE) row_valid_ff[row] <= 1'b1;
      end
   end

   // memory port: registered read, one write
   always_ff @(posedge clock) begin
      rd_ff <= mem[row];
      rv_ff <= row_valid_ff[row];
      if (state_ff == ST_WRITE) mem[row] <= {cnt_ff, chain_row};
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (state_ff == ST_EMIT && out_free) rsp_ff <= rsp_in;
      if (accept) begin
         item_ff     <= req_data;
         sym_ff      <= SYM_W'(req_data.symbol_index);
         side_ff     <= 1'b1;
         tgt_bid_ff  <= 1'b0;
         status_ff   <= 1'b0;
         rem_ff      <= req_data.quantity[SIZE_W-1:0];
         nfill_ff    <= '0;
         emit_ff     <= '0;
         bid_pres_ff <= 1'b0;
         ask_pres_ff <= 1'b0;
         bid_best_ff <= '0;
         ask_best_ff <= '0;
      end
      if (state_ff == ST_OP) begin
         if (side_ff && item_ff.action == ACT_FEED) tgt_bid_ff <= do_put;
         if (!walk_side && do_put && !any_match && full) status_ff <= 1'b1;
         if (walk_side && walking) begin
            fill_qty_ff[nfill_ff[FILL_IW-1:0]]   <= take;
            fill_price_ff[nfill_ff[FILL_IW-1:0]] <= top_lvl.price;
            nfill_ff <= nfill_ff + NFILL_W'(1);
            rem_ff   <= rem_ff - take;
         end
      end
      if (state_ff == ST_WRITE) begin
         side_ff <= 1'b0;
         if (side_ff) begin
            bid_pres_ff <= (cnt_ff != '0);
            bid_best_ff <= (cnt_ff != '0) ? top_lvl.price : '0;
         end else begin
            ask_pres_ff <= (cnt_ff != '0);
            ask_best_ff <= (cnt_ff != '0) ? top_lvl.price : '0;
         end
      end
      if (state_ff == ST_EMIT && out_free) emit_ff <= emit_ff + NFILL_W'(1);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PLO_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `PLO_ASSERT_IMP(a_cnt_bound, state_ff == ST_OP, cnt_ff <= CW'(LEVELS_PER_SIDE))
   `PLO_ASSERT_IMP(a_fill_no_status, rsp_valid && rsp_data.fill_valid, !rsp_data.status)
   `PLO_ASSERT_IMP(a_nfill_bound, state_ff == ST_EMIT, nfill_ff <= NFILL_W'(MAX_FILLS))

endmodule

// ===== test/price_level_order_book_unit_tb.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book_unit_tb
// Self-checking bench for the price level order book.
// ----------------------------------------------------------------------------
// A directed table covers reset state, extreme fields, every action, full
// sides, removal of absent prices, feeds on both sides, the highest
// symbol and long market walks. Random traffic follows, mostly well-formed
// level building and market orders on a narrow price band, under three idling
// profiles. Every response is checked against a local book model or a typed-in row.
// ----------------------------------------------------------------------------
module price_level_order_book_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plo_pkg::*;

   localparam int N_SYM     = 8;
   localparam int N_LVL     = 16;
   localparam int CYC_LIMIT = 400000;
   localparam int EXP_DEPTH = 4096;
   localparam int DIR_DEPTH = 48;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   price_level_order_book_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // local copy of the book: [symbol][side][slot], side 1 = bids
   logic [31:0] bk_price [N_SYM][2][N_LVL];
   logic [30:0] bk_size  [N_SYM][2][N_LVL];
   int          bk_count [N_SYM][2];

   // responses still owed by the DUT, in order
   rsp_type exp_buf [EXP_DEPTH];
   int      exp_wr = 0;
   int      exp_rd = 0;
   int      errors = 0;
   int      cycles = 0;
   int      rsp_seen = 0;
   int      fills_seen = 0;
   int      full_seen = 0;
   int      snd_idle = 0;    // idle percentage, sender
   int      rcv_idle = 0;    // idle percentage, receiver

   function automatic bit better(int sd, logic [31:0] a, logic [31:0] b);
      return sd == 1 ? (a > b) : (a < b);
   endfunction

   function automatic int find_lvl(int s, int sd, logic [31:0] p);
      for (int i = 0; i < bk_count[s][sd]; i++)
         if (bk_price[s][sd][i] == p) return i;
      return -1;
   endfunction

   function automatic void drop_at(int s, int sd, int idx);
      for (int i = idx; i + 1 < bk_count[s][sd]; i++) begin
         bk_price[s][sd][i] = bk_price[s][sd][i+1];
         bk_size[s][sd][i]  = bk_size[s][sd][i+1];
      end
      bk_count[s][sd]--;
   endfunction

   function automatic void drop_price(int s, int sd, logic [31:0] p);
      int k;
      k = find_lvl(s, sd, p);
      if (k >= 0) drop_at(s, sd, k);
   endfunction

   // returns 1 when the side is full and the insert is dropped
   function automatic bit put_lvl(int s, int sd, logic [31:0] p, logic [30:0] q);
      int k, pos;
      k = find_lvl(s, sd, p);
      if (k >= 0) begin
         bk_size[s][sd][k] = q;
         return 0;
      end
      if (bk_count[s][sd] >= N_LVL) return 1;
      pos = 0;
      while (pos < bk_count[s][sd] && !better(sd, p, bk_price[s][sd][pos])) pos++;
      for (int i = bk_count[s][sd]; i > pos; i--) begin
         bk_price[s][sd][i] = bk_price[s][sd][i-1];
         bk_size[s][sd][i]  = bk_size[s][sd][i-1];
      end
      bk_price[s][sd][pos] = p;
      bk_size[s][sd][pos]  = q;
      bk_count[s][sd]++;
      return 0;
   endfunction

   // applies one transaction to the book and queues the responses it causes
   function automatic void book_apply(req_type r);
      rsp_type     res [MAX_FILLS];
      rsp_type     one;
      int          nres;
      bit          pos_q, st;
      logic [30:0] qty, remaining, avail, take;
      int          s, opp;
      st    = 1'b0;
      nres  = 0;
      s     = int'(r.symbol_index);
      pos_q = !r.quantity[31] && r.quantity != 0;
      qty   = r.quantity[30:0];
      if (s < N_SYM) begin
         case (r.action)
            ACT_FEED: begin
               if (!pos_q) begin
                  drop_price(s, 1, r.price_ticks);
                  drop_price(s, 0, r.price_ticks);
               end else if (bk_count[s][1] > 0 && r.price_ticks <= bk_price[s][1][0]) begin
                  st = put_lvl(s, 1, r.price_ticks, qty);
               end else begin
                  st = put_lvl(s, 0, r.price_ticks, qty);
               end
            end
            ACT_SET: begin
               if (!pos_q) drop_price(s, int'(r.side_is_buy), r.price_ticks);
               else st = put_lvl(s, int'(r.side_is_buy), r.price_ticks, qty);
            end
            ACT_MARKET: begin
               if (pos_q) begin
                  opp = r.side_is_buy ? 0 : 1;
                  remaining = qty;
                  while (bk_count[s][opp] > 0 && remaining > 0 && nres < MAX_FILLS) begin
                     avail = bk_size[s][opp][0];
                     take  = avail < remaining ? avail : remaining;
                     one = '0;
                     one.fill_valid       = 1'b1;
                     one.fill_client_id   = r.client_id;
                     one.fill_quantity    = take;
                     one.fill_price_ticks = bk_price[s][opp][0];
                     res[nres] = one;
                     nres++;
                     remaining -= take;
                     if (avail == take) drop_at(s, opp, 0);
                     else bk_size[s][opp][0] = avail - take;
                  end
               end
            end
            default: ;
         endcase
      end
      if (nres == 0) begin
         res[0] = '0;
         nres   = 1;
      end
      for (int k = 0; k < nres; k++) begin
         one = res[k];
         if (s < N_SYM) begin
            one.bid_present    = bk_count[s][1] > 0;
            one.best_bid_ticks = bk_count[s][1] > 0 ? bk_price[s][1][0] : '0;
            one.ask_present    = bk_count[s][0] > 0;
            one.best_ask_ticks = bk_count[s][0] > 0 ? bk_price[s][0][0] : '0;
         end
         one.status      = st;
         one.last_result = (k == nres - 1);
         exp_buf[exp_wr] = one;
         exp_wr++;
      end
   endfunction

   // directed stimulus; chk set where the response is obvious from the row
   typedef struct {
      req_type r;
      bit      chk;
      rsp_type x;
   } dir_row_type;

   function automatic req_type mk(logic [1:0] a, int s, bit b, logic [31:0] p,
                                  logic [31:0] q, logic [31:0] c);
      req_type r;
      r.action = a; r.symbol_index = 3'(s); r.side_is_buy = b;
      r.price_ticks = p; r.quantity = q; r.client_id = c;
      return r;
   endfunction

   dir_row_type dir_tab [DIR_DEPTH];
   int          dir_n = 0;

   function automatic void add_row(dir_row_type d);
      dir_tab[dir_n] = d;
      dir_n++;
   endfunction

   // valid stays up between back-to-back transactions; dropped only when idling
   task automatic send(req_type r);
      while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book_apply(r);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      while (exp_rd != exp_wr) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // random request: narrow price band so levels collide, fill up and match
   function automatic req_type rand_req();
      req_type r;
      int      sel;
      r.client_id    = $urandom;
      r.side_is_buy  = 1'($urandom_range(1));
      r.symbol_index = 3'($urandom_range(99) < 80 ? $urandom_range(1) : $urandom_range(7));
      r.price_ticks  = $urandom_range(99) < 90 ? 1000 + $urandom_range(40) : $urandom;
      r.quantity     = $urandom_range(99) < 85 ? $urandom_range(1, 500) : $urandom;
      sel = $urandom_range(99);
      if (sel < 45) r.action = ACT_SET;
      else if (sel < 65) r.action = ACT_FEED;
      else if (sel < 85) r.action = ACT_MARKET;
      else r.action = ACT_QUERY;
      if (r.action == ACT_MARKET && $urandom_range(3) == 0)
         r.quantity = $urandom_range(600, 5000);
      return r;
   endfunction

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (rsp_valid && rsp_ready) begin
            if (exp_rd == exp_wr) begin
               $error("unexpected response transaction");
               errors++;
            end else begin
               rsp_type e;
               e = exp_buf[exp_rd];
               exp_rd++;
               rsp_seen++;
               if (e.fill_valid) fills_seen++;
               if (e.status) full_seen++;
               if (rsp_data.fill_valid !== e.fill_valid) begin
                  $error("fill_valid exp %0h got %0h", e.fill_valid, rsp_data.fill_valid); errors++; end
               if (rsp_data.fill_client_id !== e.fill_client_id) begin
                  $error("fill_client_id exp %0h got %0h", e.fill_client_id, rsp_data.fill_client_id); errors++; end
               if (rsp_data.fill_quantity !== e.fill_quantity) begin
                  $error("fill_quantity exp %0h got %0h", e.fill_quantity, rsp_data.fill_quantity); errors++; end
               if (rsp_data.fill_price_ticks !== e.fill_price_ticks) begin
                  $error("fill_price_ticks exp %0h got %0h", e.fill_price_ticks, rsp_data.fill_price_ticks); errors++; end
               if (rsp_data.bid_present !== e.bid_present) begin
                  $error("bid_present exp %0h got %0h", e.bid_present, rsp_data.bid_present); errors++; end
               if (rsp_data.best_bid_ticks !== e.best_bid_ticks) begin
                  $error("best_bid_ticks exp %0h got %0h", e.best_bid_ticks, rsp_data.best_bid_ticks); errors++; end
               if (rsp_data.ask_present !== e.ask_present) begin
                  $error("ask_present exp %0h got %0h", e.ask_present, rsp_data.ask_present); errors++; end
               if (rsp_data.best_ask_ticks !== e.best_ask_ticks) begin
                  $error("best_ask_ticks exp %0h got %0h", e.best_ask_ticks, rsp_data.best_ask_ticks); errors++; end
               if (rsp_data.status !== e.status) begin
                  $error("status exp %0h got %0h", e.status, rsp_data.status); errors++; end
               if (rsp_data.last_result !== e.last_result) begin
                  $error("last_result exp %0h got %0h", e.last_result, rsp_data.last_result); errors++; end
            end
         end
         if (cycles > CYC_LIMIT) begin
            $display("[price_level_order_book_unit] ERROR");
            $finish;
         end
      end
   end

   // receiver stalls, changed at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);
   end

   initial begin
      dir_row_type d;
      rsp_type     x;
      foreach (bk_count[s, sd]) bk_count[s][sd] = 0;

      // query on an empty book after reset: everything zero but last_result
      x = '0; x.last_result = 1'b1;
      d.r = mk(ACT_QUERY, 0, 0, 0, 0, 0); d.chk = 1; d.x = x; add_row(d);
      // market into empty book: single no-fill response
      d.r = mk(ACT_MARKET, 0, 1, 0, 32'd100, 32'hFFFF_FFFF); add_row(d);
      // remove absent price: no change, status 0
      d.r = mk(ACT_SET, 0, 1, 32'd55, 32'd0, 0); add_row(d);
      // highest symbol with extreme price and size
      d.r = mk(ACT_SET, 7, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0); d.chk = 0; add_row(d);
      // extremes: max price ask, zero price bid, max size
      d.r = mk(ACT_SET, 1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0); add_row(d);
      d.r = mk(ACT_SET, 1, 1, 32'd0, 32'h7FFF_FFFF, 0); add_row(d);
      d.r = mk(ACT_FEED, 1, 0, 32'd0, 32'd7, 0); add_row(d);      // at the best bid price: goes to bids
      d.r = mk(ACT_FEED, 1, 0, 32'd5, 32'd9, 0); add_row(d);      // goes to asks
      d.r = mk(ACT_SET, 1, 1, 32'd0, 32'd3, 0); add_row(d);       // update in place
      d.r = mk(ACT_MARKET, 1, 0, 0, 32'h8000_0000, 32'd1); add_row(d); // negative order
      d.r = mk(ACT_MARKET, 1, 1, 0, 32'h7FFF_FFFF, 32'hA5A5_5A5A); add_row(d);
      d.r = mk(ACT_FEED, 1, 0, 32'd0, 32'hFFFF_FFFF, 0); add_row(d); // remove both
      d.r = mk(ACT_QUERY, 1, 0, 0, 0, 0); add_row(d);
      // fill 16 ask levels on symbol 2 and overflow it
      for (int i = 0; i < N_LVL; i++) begin
         d.r = mk(ACT_SET, 2, 0, 32'd200 + i, 32'd1, 0); add_row(d);
      end
      d.r = mk(ACT_SET, 2, 0, 32'd100, 32'd1, 0); add_row(d);    // side full
      // walk all sixteen levels
      d.r = mk(ACT_MARKET, 2, 1, 0, 32'd1000, 32'h1234_5678); add_row(d);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      snd_idle = 18; rcv_idle = 66;
      for (int i = 0; i < dir_n; i++) begin
         send(dir_tab[i].r);
         // the typed-in row stands in for the model's answer
         if (dir_tab[i].chk) exp_buf[exp_wr-1] = dir_tab[i].x;
      end

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            req_valid <= 1'b0;
            wait_drain();   // sender holds off until everything is back
            snd_idle = 66; rcv_idle = 18;
         end else if (ph == 2) begin
            snd_idle = 0; rcv_idle = 0;
         end
         for (int i = 0; i < 30; i++) send(rand_req());
      end
      req_valid <= 1'b0;

      while (exp_rd != exp_wr) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("covered %0d responses, %0d fills, %0d dropped inserts",
               rsp_seen, fills_seen, full_seen);
      if (errors == 0) $display("[price_level_order_book_unit] OK");
      else $display("[price_level_order_book_unit] ERROR");
      $finish;
   end

endmodule
